FILE: rtl/cfi_pkg.sv
// ----------------------------------------------------------------------------
// cfi_pkg: shared types and constants of the color fade interpolator
// Register indexes, reset values, datapath widths and the divider handshake.
// ----------------------------------------------------------------------------
`default_nettype none

package cfi_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] REG_START_COLOR = 2'd0;
  localparam logic [1:0] REG_END_COLOR   = 2'd1;
  localparam logic [1:0] REG_FADE_PERIOD = 2'd2;
  localparam logic [1:0] REG_PING_PONG   = 2'd3;

  // reset values of the registers
  localparam logic [31:0] START_COLOR_RST = 32'hFF00_00FF;
  localparam logic [31:0] END_COLOR_RST   = 32'hFFFF_0000;
  localparam logic [15:0] FADE_PERIOD_RST = 16'd500;

  // datapath widths
  localparam int unsigned ChanW  = 8;              // one color channel
  localparam int unsigned TickW  = 16;             // ticks and period
  localparam int unsigned DvdW   = ChanW + TickW;  // product of delta and time
  localparam int unsigned QuoW   = ChanW;          // quotient stays below 256
  localparam int unsigned BitsPerCyc = 2;          // quotient bits per cycle
  localparam int unsigned DivCycles  = QuoW / BitsPerCyc;
  localparam int unsigned DivCntW    = $clog2(DivCycles);

  // request into the shared divider
  typedef struct packed {
    logic              start;
    logic [DvdW-1:0]   dividend;
    logic [TickW-1:0]  divisor;
  } div_req_t;

  // status out of the shared divider
  typedef struct packed {
    logic             done;
    logic [QuoW-1:0]  quotient;
  } div_rsp_t;

endpackage : cfi_pkg

`default_nettype wire

FILE: rtl/cfi_div.sv
// ----------------------------------------------------------------------------
// cfi_div: iterative restoring divider
// Divides a 24-bit product by the 16-bit period, two quotient bits per cycle.
// The caller guarantees the quotient fits in eight bits.
// ----------------------------------------------------------------------------
`default_nettype none

module cfi_div
  import cfi_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic [TickW-1:0]   rem_r,  rem_nxt;
  logic [QuoW-1:0]    low_r,  low_nxt;   // dividend bits still to bring down
  logic [QuoW-1:0]    quo_r,  quo_nxt;
  logic [DivCntW-1:0] cnt_r,  cnt_nxt;
  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;

  // two restoring steps per cycle
  logic [TickW:0]   trial_a, trial_b;
  logic [TickW-1:0] rem_a, rem_b;
  logic             qbit_a, qbit_b;

  always_comb begin
    trial_a = {rem_r, low_r[QuoW-1]};
    qbit_a  = (trial_a >= {1'b0, req.divisor});
    rem_a   = qbit_a ? TickW'(trial_a - {1'b0, req.divisor}) : trial_a[TickW-1:0];
    trial_b = {rem_a, low_r[QuoW-2]};
    qbit_b  = (trial_b >= {1'b0, req.divisor});
    rem_b   = qbit_b ? TickW'(trial_b - {1'b0, req.divisor}) : trial_b[TickW-1:0];
  end

  // sequencing of the iterations
  always_comb begin
    rem_nxt  = rem_r;
    low_nxt  = low_r;
    quo_nxt  = quo_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (req.start) begin
      rem_nxt  = req.dividend[DvdW-1:QuoW];
      low_nxt  = req.dividend[QuoW-1:0];
      quo_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      rem_nxt = rem_b;
      low_nxt = {low_r[QuoW-3:0], 2'b00};
      quo_nxt = {quo_r[QuoW-3:0], qbit_a, qbit_b};
      cnt_nxt = DivCntW'(cnt_r + 1'b1);
      if (cnt_r == DivCntW'(DivCycles - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    low_r <= low_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule : cfi_div

`default_nettype wire

FILE: rtl/color_fade_interpolator.sv
// ----------------------------------------------------------------------------
// color_fade_interpolator: linear RGBA fade with one-shot and ping-pong modes
// Sequencer around one shared divider, one channel at a time.
// ----------------------------------------------------------------------------
// The fade time and direction of each input transaction are updated at its
// acceptance edge. Each of the four channels then forms delta times time and
// starts the divider in ST_MUL, waits in ST_DIV while the divider works out
// the quotient two bits at a time, and applies the quotient once the divider
// is done. The push state then loads the output register. The block is ready
// again in the cycle that the result becomes valid, so a new transaction is
// taken only once the last one has its result. The block takes a new
// transaction only in its idle state, but a finished result may wait in the
// output register while the next one is already accepted. A result that finds
// the output register still full holds the sequencer in its push state.
// Configuration writes apply at once and are meant to be made while the block
// is idle; they never change the fade state.
`default_nettype none

module color_fade_interpolator
  import cfi_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // configuration port
  input  wire logic        cfg_wr_en,
  input  wire logic [1:0]  cfg_addr,
  input  wire logic [31:0] cfg_wdata,
  // input stream
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [31:0] in_tdata,   // time_step [15:0], item_age [31:16]
  // result stream
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [31:0]      out_tdata   // red [7:0], green [15:8], blue [23:16],
                                       // alpha [31:24]
);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_MUL  = 2'd1;
  localparam logic [1:0] ST_DIV  = 2'd2;
  localparam logic [1:0] ST_PUSH = 2'd3;

  // configuration registers
  logic [31:0]      start_color_r;
  logic [31:0]      end_color_r;
  logic [TickW-1:0] fade_period_r;
  logic             ping_pong_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_color_r <= START_COLOR_RST;
      end_color_r   <= END_COLOR_RST;
      fade_period_r <= FADE_PERIOD_RST;
      ping_pong_r   <= 1'b0;
    end else if (cfg_wr_en) begin
      case (cfg_addr)
        REG_START_COLOR: start_color_r <= cfg_wdata;
        REG_END_COLOR:   end_color_r   <= cfg_wdata;
        REG_FADE_PERIOD: fade_period_r <= cfg_wdata[TickW-1:0];
        REG_PING_PONG:   ping_pong_r   <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // sequencer and datapath registers
  logic [1:0]       state_r,    state_nxt;
  logic [1:0]       ch_r,       ch_nxt;
  logic [TickW-1:0] elapsed_r,  elapsed_nxt;
  logic             rev_r,      rev_nxt;
  logic [TickW-1:0] t_r,        t_nxt;
  logic             to_end_r,   to_end_nxt;   // one-shot age at or past period
  logic [31:0]      from_r,     from_nxt;
  logic [31:0]      to_r,       to_nxt;
  logic [ChanW-1:0] a_r,        a_nxt;
  logic [ChanW-1:0] b_r,        b_nxt;
  logic             up_r,       up_nxt;
  logic [31:0]      res_r,      res_nxt;
  logic             out_vld_r,  out_vld_nxt;
  logic [31:0]      out_dat_r,  out_dat_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;

  logic [TickW-1:0] in_step, in_age;
  logic [TickW:0]   sum;
  logic             in_fire, out_fire;
  logic [ChanW-1:0] ch_a, ch_b, mag;
  logic [ChanW-1:0] chan_val;

  assign in_step  = in_tdata[TickW-1:0];
  assign in_age   = in_tdata[2*TickW-1:TickW];
  assign in_fire  = in_tvalid && in_tready;
  assign out_fire = out_vld_r && out_tready;
  assign sum      = {1'b0, elapsed_r} + {1'b0, in_step};

  // channel operands for the multiply ahead of the divider
  assign ch_a = from_r[ch_r*ChanW +: ChanW];
  assign ch_b = to_r[ch_r*ChanW +: ChanW];
  assign mag  = (ch_b >= ch_a) ? ChanW'(ch_b - ch_a) : ChanW'(ch_a - ch_b);

  always_comb begin
    div_req.start    = (state_r == ST_MUL);
    div_req.dividend = DvdW'(mag) * DvdW'(t_r);
    div_req.divisor  = fade_period_r;
  end

  // channel result once the quotient is in
  always_comb begin
    if (to_end_r) begin
      chan_val = b_r;
    end else if (t_r == '0) begin
      chan_val = a_r;
    end else if (up_r) begin
      chan_val = ChanW'(a_r + div_rsp.quotient);
    end else begin
      chan_val = ChanW'(a_r - div_rsp.quotient);
    end
  end

  always_comb begin
    state_nxt   = state_r;
    ch_nxt      = ch_r;
    elapsed_nxt = elapsed_r;
    rev_nxt     = rev_r;
    t_nxt       = t_r;
    to_end_nxt  = to_end_r;
    from_nxt    = from_r;
    to_nxt      = to_r;
    a_nxt       = a_r;
    b_nxt       = b_r;
    up_nxt      = up_r;
    res_nxt     = res_r;
    out_vld_nxt = out_fire ? 1'b0 : out_vld_r;
    out_dat_nxt = out_dat_r;
    case (state_r)
      ST_IDLE: begin
        if (in_fire) begin
          // fade time and direction for this update
          if (ping_pong_r) begin
            if (sum >= {1'b0, fade_period_r}) begin
              rev_nxt     = !rev_r;
              elapsed_nxt = '0;
            end else begin
              elapsed_nxt = sum[TickW-1:0];
            end
            t_nxt      = elapsed_nxt;
            to_end_nxt = 1'b0;
          end else begin
            t_nxt      = in_age;
            to_end_nxt = (in_age >= fade_period_r);
          end
          from_nxt  = rev_nxt ? end_color_r : start_color_r;
          to_nxt    = rev_nxt ? start_color_r : end_color_r;
          ch_nxt    = '0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        a_nxt     = ch_a;
        b_nxt     = ch_b;
        up_nxt    = (ch_b >= ch_a);
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_rsp.done) begin
          res_nxt[ch_r*ChanW +: ChanW] = chan_val;
          if (ch_r == 2'd3) begin
            state_nxt = ST_PUSH;
          end else begin
            ch_nxt    = 2'(ch_r + 1'b1);
            state_nxt = ST_MUL;
          end
        end
      end
      ST_PUSH: begin
        if (!out_vld_r || out_tready) begin
          out_vld_nxt = 1'b1;
          out_dat_nxt = res_r;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      ch_r      <= '0;
      elapsed_r <= '0;
      rev_r     <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ch_r      <= ch_nxt;
      elapsed_r <= elapsed_nxt;
      rev_r     <= rev_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r       <= t_nxt;
    to_end_r  <= to_end_nxt;
    from_r    <= from_nxt;
    to_r      <= to_nxt;
    a_r       <= a_nxt;
    b_r       <= b_nxt;
    up_r      <= up_nxt;
    res_r     <= res_nxt;
    out_dat_r <= out_dat_nxt;
  end

  // shared divider
  cfi_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tdata  = out_dat_r;

  // accepted transaction always starts the first channel
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == ST_MUL) && (ch_r == 2'd0))
    else $error("accepted transaction did not start channel 0");

  // divider reports completion only while the sequencer waits for it
  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_rsp.done |-> (state_r == ST_DIV))
    else $error("divider done outside the wait state");

  // result is pushed only after the last channel
  a_push_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_PUSH) |-> (ch_r == 2'd3))
    else $error("push state reached before the last channel");

endmodule : color_fade_interpolator

`default_nettype wire
